// ===== rtl/core/vn_pkg.sv =====
// ----------------------------------------------------------------------------
// vn_pkg: shared definitions for the vector normalizer
// Widths, constants and the item types that move along the cell chains.
// ----------------------------------------------------------------------------
package vn_pkg;

  localparam int COMPONENT_WIDTH = 32;
  localparam int FRACTION_BITS   = 16;

  localparam int SUM_W  = 2 * COMPONENT_WIDTH;
  localparam int REM_W  = COMPONENT_WIDTH + 1;
  localparam int QUOT_W = FRACTION_BITS + 1;
  localparam int OUT_W  = FRACTION_BITS + 2;
  localparam int TOL_W  = 17;
  localparam int WIDE_W0 = (COMPONENT_WIDTH > QUOT_W) ? COMPONENT_WIDTH : QUOT_W;
  localparam int WIDE_W  = (WIDE_W0 > TOL_W) ? WIDE_W0 : TOL_W;

  localparam logic [TOL_W-1:0]  TOL_RESET = TOL_W'(1);
  localparam logic [WIDE_W-1:0] ONE_WIDE  = WIDE_W'(1) << FRACTION_BITS;

  typedef logic [COMPONENT_WIDTH-1:0] mag_t;

  typedef struct packed {
    logic              valid;
    logic [SUM_W-1:0]  rad;
    logic [REM_W-1:0]  rem;
    mag_t              root;
    mag_t [2:0]        mag;
    logic [2:0]        neg;
  } sq_item_t;

  typedef struct packed {
    logic                    valid;
    logic                    degen;
    mag_t                    divisor;
    mag_t [2:0]              rem;
    logic [2:0][QUOT_W-1:0]  quot;
    logic [2:0]              neg;
  } dv_item_t;

endpackage

// ===== rtl/core/vn_sqrt_cell.sv =====
// ----------------------------------------------------------------------------
// vn_sqrt_cell: one root digit of the square root chain
// Brings down two radicand bits and settles one bit of the root.
// ----------------------------------------------------------------------------
module vn_sqrt_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  vn_pkg::sq_item_t in_item,
  output vn_pkg::sq_item_t out_item_r
);
  import vn_pkg::*;

  logic [REM_W+1:0] acc;
  logic [REM_W+1:0] trial;
  logic [REM_W+1:0] diff;
  logic             ge;
  sq_item_t         item_nxt;

  always_comb begin
    acc   = {in_item.rem, in_item.rad[SUM_W-1 -: 2]};
    trial = {1'b0, in_item.root, 2'b01};
    diff  = acc - trial;
    ge    = (acc >= trial);
    item_nxt     = in_item;
    item_nxt.rad = in_item.rad << 2;
    if (ge) begin
      item_nxt.rem  = diff[REM_W-1:0];
      item_nxt.root = {in_item.root[COMPONENT_WIDTH-2:0], 1'b1};
    end else begin
      item_nxt.rem  = acc[REM_W-1:0];
      item_nxt.root = {in_item.root[COMPONENT_WIDTH-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_item_r.valid <= 1'b0;
    end else if (en) begin
      out_item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/vn_div_cell.sv =====
// ----------------------------------------------------------------------------
// vn_div_cell: one quotient bit of the fraction divider chain
// Restoring division step for all three components at once.
// ----------------------------------------------------------------------------
module vn_div_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             en,
  input  vn_pkg::dv_item_t in_item,
  output vn_pkg::dv_item_t out_item_r
);
  import vn_pkg::*;

  logic [COMPONENT_WIDTH:0] acc  [3];
  logic [COMPONENT_WIDTH:0] diff [3];
  logic [2:0]               ge;
  dv_item_t                 item_nxt;

  always_comb begin
    item_nxt = in_item;
    for (int k = 0; k < 3; k++) begin
      acc[k]  = {in_item.rem[k], 1'b0};
      diff[k] = acc[k] - {1'b0, in_item.divisor};
      ge[k]   = (acc[k] >= {1'b0, in_item.divisor});
      item_nxt.rem[k] = ge[k] ? diff[k][COMPONENT_WIDTH-1:0] : acc[k][COMPONENT_WIDTH-1:0];
      // A degenerate item already carries its final quotient.
      if (!in_item.degen) begin
        item_nxt.quot[k] = {in_item.quot[k][QUOT_W-2:0], ge[k]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_item_r.valid <= 1'b0;
    end else if (en) begin
      out_item_r <= item_nxt;
    end
  end

endmodule

// ===== rtl/core/vector3_normalize_top.sv =====
// ----------------------------------------------------------------------------
// vector3_normalize_top: 3D vector normalizer, signed Q16.16
// Magnitude by a digit-per-cell square root chain, then a bit-per-cell
// fraction divider chain, with tolerance handling and zero snapping.
// ----------------------------------------------------------------------------
// Usage:
// The input channel (in_valid/in_ready) takes one vector per transfer; the
// result channel (out_valid/out_ready) returns the unit vector and the
// degenerate flag, one result per input, in order.
// The pipeline runs through registers for absolute value, squaring and
// summing, one cell per root bit, a register for the tolerance check and
// first quotient bit, one cell per fraction bit of the Q16.16 format, and
// the output register.
// Throughput is one vector per cycle while the receiver keeps up: every
// cell advances together, so a new item enters while others are in flight.
// When the receiver stalls with a result waiting, the whole pipeline holds
// and in_ready drops in the same cycle; nothing is lost or repeated.
// Reset (synchronous, active low) empties the pipeline and sets the
// tolerance register to 1 LSB. The tolerance is written through cfg_we and
// cfg_wdata and should only change while no vector is in flight.
// ----------------------------------------------------------------------------
module vector3_normalize_top (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [vn_pkg::TOL_W-1:0]             cfg_wdata,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic signed [vn_pkg::COMPONENT_WIDTH-1:0] in_x,
  input  logic signed [vn_pkg::COMPONENT_WIDTH-1:0] in_y,
  input  logic signed [vn_pkg::COMPONENT_WIDTH-1:0] in_z,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [vn_pkg::OUT_W-1:0]      out_unit_x,
  output logic signed [vn_pkg::OUT_W-1:0]      out_unit_y,
  output logic signed [vn_pkg::OUT_W-1:0]      out_unit_z,
  output logic                                 out_degenerate
);
  import vn_pkg::*;

  // Global advance: the pipeline moves unless a result waits unaccepted.
  logic en;

  logic [TOL_W-1:0] tol_r;

  // Stage A: absolute values.
  logic             a_valid_r;
  mag_t             a_mag_r [3];
  logic [2:0]       a_neg_r;
  logic signed [COMPONENT_WIDTH-1:0] comp_in [3];

  // Stage B: squares.
  logic             b_valid_r;
  logic [SUM_W-1:0] b_sq_r  [3];
  mag_t             b_mag_r [3];
  logic [2:0]       b_neg_r;

  // Square root chain; entry 0 is the summing register.
  sq_item_t sq_chain [COMPONENT_WIDTH+1];
  sq_item_t sq_head_nxt;

  // Divider chain; entry 0 is the tolerance check register.
  dv_item_t dv_chain [FRACTION_BITS+1];
  dv_item_t dv_head_nxt;

  // Output register.
  logic                    out_valid_r;
  logic signed [OUT_W-1:0] out_unit_r [3];
  logic                    out_degen_r;
  logic signed [OUT_W-1:0] unit_nxt   [3];

  assign en       = !out_valid_r || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tol_r <= TOL_RESET;
    end else if (cfg_we) begin
      tol_r <= cfg_wdata;
    end
  end

  assign comp_in[0] = in_x;
  assign comp_in[1] = in_y;
  assign comp_in[2] = in_z;

  // The most negative component negates to 2^(W-1), which is exact as unsigned.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else if (en) begin
      a_valid_r <= in_valid;
      for (int k = 0; k < 3; k++) begin
        a_neg_r[k] <= comp_in[k][COMPONENT_WIDTH-1];
        a_mag_r[k] <= comp_in[k][COMPONENT_WIDTH-1] ? mag_t'(-comp_in[k]) : mag_t'(comp_in[k]);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      b_valid_r <= 1'b0;
    end else if (en) begin
      b_valid_r <= a_valid_r;
      b_neg_r   <= a_neg_r;
      for (int k = 0; k < 3; k++) begin
        b_sq_r[k]  <= SUM_W'(a_mag_r[k]) * SUM_W'(a_mag_r[k]);
        b_mag_r[k] <= a_mag_r[k];
      end
    end
  end

  // The sum of three squares stays below 2^SUM_W, so no carry is dropped.
  always_comb begin
    sq_head_nxt.valid  = b_valid_r;
    sq_head_nxt.rad    = b_sq_r[0] + b_sq_r[1] + b_sq_r[2];
    sq_head_nxt.rem    = '0;
    sq_head_nxt.root   = '0;
    sq_head_nxt.neg    = b_neg_r;
    for (int k = 0; k < 3; k++) begin
      sq_head_nxt.mag[k] = b_mag_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sq_chain[0].valid <= 1'b0;
    end else if (en) begin
      sq_chain[0] <= sq_head_nxt;
    end
  end

  for (genvar g = 0; g < COMPONENT_WIDTH; g++) begin : g_sqrt
    vn_sqrt_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_item    (sq_chain[g]),
      .out_item_r (sq_chain[g+1])
    );
  end

  // Tolerance check and the integer quotient bit. A degenerate vector skips
  // division: its component, clamped to 1.0, is the quotient.
  always_comb begin
    sq_item_t          s;
    logic [WIDE_W-1:0] m_w;
    logic [WIDE_W-1:0] mag_w;
    logic              ge;
    s = sq_chain[COMPONENT_WIDTH];
    m_w = WIDE_W'(s.root);
    dv_head_nxt.valid   = s.valid;
    dv_head_nxt.degen   = (m_w <= WIDE_W'(tol_r));
    dv_head_nxt.divisor = s.root;
    dv_head_nxt.neg     = s.neg;
    for (int k = 0; k < 3; k++) begin
      mag_w = WIDE_W'(s.mag[k]);
      ge    = (s.mag[k] >= s.root);
      dv_head_nxt.rem[k] = ge ? (s.mag[k] - s.root) : s.mag[k];
      if (dv_head_nxt.degen) begin
        dv_head_nxt.quot[k] = (mag_w > ONE_WIDE) ? ONE_WIDE[QUOT_W-1:0] : mag_w[QUOT_W-1:0];
      end else begin
        dv_head_nxt.quot[k] = QUOT_W'(ge);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_chain[0].valid <= 1'b0;
    end else if (en) begin
      dv_chain[0] <= dv_head_nxt;
    end
  end

  for (genvar g = 0; g < FRACTION_BITS; g++) begin : g_div
    vn_div_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .en         (en),
      .in_item    (dv_chain[g]),
      .out_item_r (dv_chain[g+1])
    );
  end

  // Small quotients snap to zero, then the sign is restored.
  always_comb begin
    logic [QUOT_W-1:0] q;
    for (int k = 0; k < 3; k++) begin
      q = dv_chain[FRACTION_BITS].quot[k];
      if (WIDE_W'(q) < WIDE_W'(tol_r)) begin
        q = '0;
      end
      unit_nxt[k] = dv_chain[FRACTION_BITS].neg[k] ? -$signed(OUT_W'(q)) : $signed(OUT_W'(q));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_chain[FRACTION_BITS].valid;
      out_degen_r <= dv_chain[FRACTION_BITS].degen;
      for (int k = 0; k < 3; k++) begin
        out_unit_r[k] <= unit_nxt[k];
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_unit_x     = out_unit_r[0];
  assign out_unit_y     = out_unit_r[1];
  assign out_unit_z     = out_unit_r[2];
  assign out_degenerate = out_degen_r;

`ifndef SYNTHESIS
  localparam logic signed [OUT_W-1:0] POS_ONE = $signed(OUT_W'(ONE_WIDE));
  localparam logic signed [OUT_W-1:0] NEG_ONE = -$signed(OUT_W'(ONE_WIDE));

  a_unit_x_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_unit_r[0] <= POS_ONE) && (out_unit_r[0] >= NEG_ONE))
    else $error("unit_x outside +/-1.0");

  a_unit_yz_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_unit_r[1] <= POS_ONE) && (out_unit_r[1] >= NEG_ONE) &&
                    (out_unit_r[2] <= POS_ONE) && (out_unit_r[2] >= NEG_ONE))
    else $error("unit_y or unit_z outside +/-1.0");

  a_chain_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(dv_chain[FRACTION_BITS].valid) && $stable(sq_chain[COMPONENT_WIDTH].valid))
    else $error("cell chain moved during a stall");

  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid_r && !sq_chain[0].valid && !dv_chain[0].valid)
    else $error("pipeline not empty after reset");
`endif

endmodule

// ===== sim/vector3_normalize_top_tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vector3_normalize_top_tb: self-checking bench for the vector normalizer
// Directed vectors and random ones go through the block under several
// tolerance settings and several idle patterns on both channels. Every
// result transfer is compared with a unit vector predicted in the bench.
// ----------------------------------------------------------------------------
module vector3_normalize_top_tb;
  import vn_pkg::*;

  localparam int CW = COMPONENT_WIDTH;
  localparam int FB = FRACTION_BITS;
  localparam int LATENCY = 3 + CW + 1 + FB + 1;
  localparam int WATCHDOG_LIMIT = 20000;

  // One expected result, in the order the block returns them.
  typedef struct {
    logic signed [OUT_W-1:0] ux;
    logic signed [OUT_W-1:0] uy;
    logic signed [OUT_W-1:0] uz;
    logic                    degen;
  } unit_vec_t;

  // One row of directed stimulus. When has_exp is set the expected result
  // below is used as written, otherwise the predictor supplies it.
  typedef struct {
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    bit            has_exp;
    unit_vec_t     exp;
  } vec_row_t;

  logic clk;
  logic rst_n;
  logic cfg_we;
  logic [TOL_W-1:0] cfg_wdata;
  logic in_valid;
  logic in_ready;
  logic signed [CW-1:0] in_x, in_y, in_z;
  logic out_valid;
  logic out_ready;
  logic signed [OUT_W-1:0] out_unit_x, out_unit_y, out_unit_z;
  logic out_degenerate;

  vector3_normalize_top DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_ready(in_ready),
    .in_x(in_x), .in_y(in_y), .in_z(in_z),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_unit_x(out_unit_x), .out_unit_y(out_unit_y), .out_unit_z(out_unit_z),
    .out_degenerate(out_degenerate)
  );

  // The bench's copy of the tolerance register.
  logic [TOL_W-1:0] tol_shadow;

  unit_vec_t pending_units[$];
  int unsigned errors;
  int unsigned vectors_sent;
  int unsigned results_checked;
  int unsigned degenerate_seen;

  // Idle percentages for each side; a hold-off counter for the receiver.
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned recv_holdoff;
  int unsigned idle_cycles;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Exact floor square root of a sum of three squares; the root fits in
  // CW+1 bits, so it is built one bit at a time from the top.
  function automatic logic [CW:0] floor_root(input logic [2*CW+1:0] s);
    logic [CW:0] r;
    logic [CW:0] t;
    r = '0;
    for (int i = CW; i >= 0; i--) begin
      t = r | ((CW+1)'(1) << i);
      if ((2*CW+2)'(t) * (2*CW+2)'(t) <= s) r = t;
    end
    return r;
  endfunction

  // Full prediction of one result from the three components and the
  // current tolerance.
  function automatic unit_vec_t normalize_vec(input logic [CW-1:0] x,
                                              input logic [CW-1:0] y,
                                              input logic [CW-1:0] z);
    logic [CW-1:0]     raw[3];
    logic [CW:0]       mag[3];
    logic              neg[3];
    logic [2*CW+1:0]   sum;
    logic [CW:0]       root;
    logic [CW+FB+1:0]  q;
    logic [OUT_W-1:0]  res[3];
    unit_vec_t         u;
    raw[0] = x; raw[1] = y; raw[2] = z;
    sum = '0;
    for (int i = 0; i < 3; i++) begin
      neg[i] = raw[i][CW-1];
      // Two's complement of the most negative value keeps its magnitude
      // exactly because the magnitude has one spare bit.
      mag[i] = neg[i] ? ((CW+1)'(0) - {1'b1, raw[i]}) : {1'b0, raw[i]};
      sum += (2*CW+2)'(mag[i]) * (2*CW+2)'(mag[i]);
    end
    root = floor_root(sum);
    u.degen = (root <= (CW+1)'(tol_shadow));
    for (int i = 0; i < 3; i++) begin
      if (u.degen) begin
        q = (CW+FB+2)'(mag[i]);
        if (q > (CW+FB+2)'(1) << FB) q = (CW+FB+2)'(1) << FB;
      end else begin
        q = ((CW+FB+2)'(mag[i]) << FB) / (CW+FB+2)'(root);
      end
      if (q < (CW+FB+2)'(tol_shadow)) q = '0;
      res[i] = neg[i] ? (OUT_W'(0) - OUT_W'(q)) : OUT_W'(q);
    end
    u.ux = res[0]; u.uy = res[1]; u.uz = res[2];
    return u;
  endfunction

  // Sender: valid stays up between back-to-back items and drops only for
  // idle cycles. It holds the payload until the transfer happens, then
  // queues the expectation. The tolerance only changes between phases, so
  // predicting at acceptance time is safe.
  task automatic send_vec(input logic [CW-1:0] x, input logic [CW-1:0] y,
                          input logic [CW-1:0] z, input bit has_exp,
                          input unit_vec_t exp);
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_valid <= 1'b1;
    in_x <= x; in_y <= y; in_z <= z;
    do @(posedge clk); while (!in_ready);
    pending_units.push_back(has_exp ? exp : normalize_vec(x, y, z));
    vectors_sent++;
  endtask

  // Waits for every queued result, plus the pipeline depth in case a
  // write would otherwise land on an item still in flight.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_units.size() != 0) @(posedge clk);
    repeat (LATENCY + 4) @(posedge clk);
  endtask

  task automatic write_tolerance(input logic [TOL_W-1:0] val);
    cfg_we <= 1'b1;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    tol_shadow = val;
  endtask

  // Random vector biased toward interesting magnitudes: small values near
  // the tolerance, values near the extremes, and fully random words.
  function automatic logic [CW-1:0] rand_comp();
    case ($urandom_range(5))
      0: return CW'($urandom_range(0, 8)) * ($urandom_range(1) ? -1 : 1);
      1: return CW'($signed($urandom_range(0, 262143)) - 131072);
      2: return $urandom_range(1) ? {1'b1, (CW-1)'($urandom_range(3))}
                                  : CW'(32'h7FFF_FFFF) - CW'($urandom_range(3));
      default: return CW'($urandom());
    endcase
  endfunction

  // Receiver: idles at random, with an optional long hold-off counted here.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (recv_holdoff != 0) begin
      recv_holdoff <= recv_holdoff - 1;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result checker: compare every result transfer with the oldest
  // expectation, field by field.
  always @(posedge clk) begin
    unit_vec_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_units.size() == 0) begin
        $error("result transfer with nothing expected");
        errors++;
      end else begin
        e = pending_units.pop_front();
        results_checked++;
        if (out_degenerate) degenerate_seen++;
        if (out_unit_x !== e.ux) begin
          $error("unit_x expected %0d actual %0d", e.ux, out_unit_x);
          errors++;
        end
        if (out_unit_y !== e.uy) begin
          $error("unit_y expected %0d actual %0d", e.uy, out_unit_y);
          errors++;
        end
        if (out_unit_z !== e.uz) begin
          $error("unit_z expected %0d actual %0d", e.uz, out_unit_z);
          errors++;
        end
        if (out_degenerate !== e.degen) begin
          $error("degenerate expected %0b actual %0b", e.degen, out_degenerate);
          errors++;
        end
      end
    end
  end

  // Watchdog: counts cycles with no transfer on either channel.
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  localparam logic [CW-1:0] MAXP = 32'h7FFF_FFFF;
  localparam logic [CW-1:0] MAXN = 32'h8000_0000;
  localparam logic [CW-1:0] ONE  = 32'h0001_0000;

  vec_row_t directed[$];

  function automatic vec_row_t row(input logic [CW-1:0] x, input logic [CW-1:0] y,
                                   input logic [CW-1:0] z, input bit has_exp,
                                   input int ex, input int ey, input int ez,
                                   input bit ed);
    vec_row_t r;
    r.x = x; r.y = y; r.z = z; r.has_exp = has_exp;
    r.exp.ux = OUT_W'(ex); r.exp.uy = OUT_W'(ey); r.exp.uz = OUT_W'(ez);
    r.exp.degen = ed;
    return r;
  endfunction

  initial begin
    unit_vec_t none;
    int unsigned tol_set[5];
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_valid = 1'b0;
    in_x = '0; in_y = '0; in_z = '0;
    errors = 0; vectors_sent = 0; results_checked = 0; degenerate_seen = 0;
    send_idle_pct = 0; recv_idle_pct = 0; recv_holdoff = 0; idle_cycles = 0;
    tol_shadow = TOL_RESET;
    none = '{default: '0};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed rows, tolerance at its reset value of one LSB. The zero
    // vector is degenerate; a single axis above the tolerance gives +/-1.0.
    directed.push_back(row(0, 0, 0, 1, 0, 0, 0, 1));
    directed.push_back(row(ONE, 0, 0, 1, 65536, 0, 0, 0));
    directed.push_back(row(0, -ONE, 0, 1, 0, -65536, 0, 0));
    directed.push_back(row(0, 0, MAXP, 1, 0, 0, 65536, 0));
    directed.push_back(row(MAXN, 0, 0, 1, -65536, 0, 0, 0));
    directed.push_back(row(1, 0, 0, 1, 1, 0, 0, 1));
    directed.push_back(row(MAXN, MAXN, MAXN, 0, 0, 0, 0, 0));
    directed.push_back(row(MAXP, MAXP, MAXP, 0, 0, 0, 0, 0));
    directed.push_back(row(MAXP, MAXN, MAXP, 0, 0, 0, 0, 0));
    directed.push_back(row(ONE, ONE, ONE, 0, 0, 0, 0, 0));
    directed.push_back(row(3, -4, 0, 0, 0, 0, 0, 0));
    directed.push_back(row(32'hFFFF_FFFF, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0));
    directed.push_back(row(1, 1, 1, 0, 0, 0, 0, 0));
    foreach (directed[i])
      send_vec(directed[i].x, directed[i].y, directed[i].z,
               directed[i].has_exp, directed[i].exp);
    drain_results();

    // Tolerance at one: degenerate quotients saturate at one and small
    // components snap to zero.
    write_tolerance(TOL_W'(65536));
    send_vec(40000, -50000, 0, 0, none);
    send_vec(0, 0, 0, 0, none);
    send_vec(MAXN, 5, -5, 0, none);
    send_vec(70000, 0, 0, 0, none);
    drain_results();

    // Random part in phases, each setting a tolerance and an idle pattern.
    tol_set = '{0, 1, 65536, 300, 0};
    for (int ph = 0; ph < 5; ph++) begin
      write_tolerance(ph == 4 ? TOL_W'($urandom_range(0, 65536)) : TOL_W'(tol_set[ph]));
      case (ph)
        0, 1: begin send_idle_pct = 36; recv_idle_pct = 86; end
        2, 3: begin send_idle_pct = 86; recv_idle_pct = 36; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      // One long receiver hold-off while the sender keeps offering, so the
      // pipeline fills and in_ready drops.
      if (ph == 4) recv_holdoff = 300;
      repeat (340) send_vec(rand_comp(), rand_comp(), rand_comp(), 0, none);
      drain_results();
    end

    $display("Sent %0d vectors, checked %0d results (%0d degenerate)",
             vectors_sent, results_checked, degenerate_seen);
    $display("Tolerance swept 0 to 1.0; idle patterns and a long result stall done");
    if (errors == 0 && pending_units.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
